// ----- src/poi_pkg.sv -----
// shared types, constants and sine table builder for the planar odometry integrator
`default_nettype none

package poi_pkg;

    localparam int POS_W  = 48;
    localparam int HEAD_W = 32;

    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_rate;
        logic        [15:0] elapsed_ms;
    } sample_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic        [HEAD_W-1:0] yaw_angle;
        logic                     integrated;
    } pose_t;

    // binary-angle units per 1e-7 rad, q16
    localparam logic signed [24:0] YAW_K_Q16 = 25'sd4479813;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam logic [HEAD_W-1:0] QUARTER_TURN = 32'h4000_0000;

    localparam longint PI_HALF_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint TRIG_ONE    = 64'sd32767;
    localparam longint TAYLOR_DEN [1:7] = '{6, 20, 42, 72, 110, 156, 210};

    // one quarter-wave entry, round(32767 * sin(pi/2 * i / 2^abits)) via q30 series
    function automatic logic [14:0] sine_entry(input int idx, input int abits);
        longint xq;
        longint x2;
        longint term;
        longint sum;
        longint v;
        xq = (PI_HALF_Q30 * longint'(idx)) >>> abits;
        x2 = (xq * xq) / ONE_Q30;
        term = xq;
        sum = xq;
        for (int k = 1; k <= 7; k++)
        begin
            term = -((term * x2) / ONE_Q30) / TAYLOR_DEN[k];
            sum = sum + term;
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (sum * TRIG_ONE + (ONE_Q30 / 2)) / ONE_Q30;
        if (v > TRIG_ONE)
        begin
            v = TRIG_ONE;
        end
        return v[14:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/planar_odometry_integrator_top.sv -----
// planar odometry integrator: microcoded dead-reckoning datapath on one shared multiplier
// the pose is loaded into the output register at the EMIT step; the priming sample jumps from PATH to EMIT
// a new sample is taken only in IDLE, once the 8-step program on one multiplier has run; EMIT waits on a stalled output
// the output register frees the sequencer as soon as the pose is loaded
// reset clears pose, heading and priming flag; the first sample only primes
`default_nettype none

module planar_odometry_integrator_top #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             sample_valid,
    output logic                  sample_stall,
    input  wire poi_pkg::sample_t sample,
    output logic                  pose_valid,
    input  wire logic             pose_stall,
    output poi_pkg::pose_t        pose
);

    localparam int QTAB_SIZE = 1 << SINE_ADDR_BITS;
    localparam int AW        = SINE_ADDR_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PATH, ST_XMUL, ST_XADD, ST_YADD, ST_HMUL, ST_HEAD, ST_EMIT
    } step_e;

    typedef enum logic [1:0] {
        COND_NEVER, COND_NO_REQ, COND_UNPRIMED, COND_OUT_BUSY
    } cond_e;

    typedef enum logic [1:0] {
        A_SPEED, A_RATE, A_PROD, A_PATH
    } a_sel_e;

    typedef enum logic [1:0] {
        B_DT, B_TRIG, B_YAW_K
    } b_sel_e;

    typedef struct packed {
        logic   accept;
        cond_e  cond;
        step_e  target;
        a_sel_e a_sel;
        b_sel_e b_sel;
        logic   rom_cos;
        logic   ld_path;
        logic   ld_x;
        logic   ld_y;
        logic   ld_head;
        logic   emit;
    } ucode_t;

    localparam ucode_t PROGRAM [8] = '{
        '{1'b1, COND_NO_REQ,   ST_IDLE, A_SPEED, B_DT,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, COND_UNPRIMED, ST_EMIT, A_SPEED, B_DT,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, COND_NEVER,    ST_IDLE, A_PROD,  B_TRIG,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, COND_NEVER,    ST_IDLE, A_PATH,  B_TRIG,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, COND_NEVER,    ST_IDLE, A_RATE,  B_DT,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, COND_NEVER,    ST_IDLE, A_PROD,  B_YAW_K, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, COND_NEVER,    ST_IDLE, A_SPEED, B_DT,    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0},
        '{1'b0, COND_OUT_BUSY, ST_EMIT, A_SPEED, B_DT,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}
    };

    typedef logic [14:0] rom_arr_t [QTAB_SIZE+1];

    function automatic rom_arr_t build_rom();
        rom_arr_t r;
        for (int i = 0; i <= QTAB_SIZE; i++)
        begin
            r[i] = poi_pkg::sine_entry(i, AW);
        end
        return r;
    endfunction

    localparam rom_arr_t SINE_ROM = build_rom();
    localparam logic [AW:0] QTAB_TOP = (AW+1)'(QTAB_SIZE);

    step_e                              pc_reg;
    logic                               primed_reg;
    logic signed [poi_pkg::POS_W-1:0]   x_reg;
    logic signed [poi_pkg::POS_W-1:0]   y_reg;
    logic        [poi_pkg::HEAD_W-1:0]  head_reg;
    logic signed [57:0]                 mul_reg;
    logic signed [32:0]                 path_reg;
    logic        [14:0]                 rom_data_reg;
    logic                               rom_neg_reg;
    logic signed [15:0]                 v_reg;
    logic signed [15:0]                 w_reg;
    logic        [15:0]                 dt_reg;
    poi_pkg::pose_t                     pose_reg;
    logic                               pose_valid_reg;

    ucode_t                             cw;
    logic                               sample_fire;
    logic                               out_busy;
    logic                               cond_hit;
    logic                               emit_fire;
    logic signed [32:0]                 mul_a;
    logic signed [24:0]                 mul_b;
    logic signed [57:0]                 prod;
    logic signed [15:0]                 trig;
    logic        [poi_pkg::HEAD_W-1:0]  angle;
    logic        [AW-1:0]               idx;
    logic        [AW:0]                 rom_addr;
    logic signed [57:0]                 pos_sh;
    logic signed [57:0]                 head_sh;
    logic signed [poi_pkg::POS_W-1:0]   acc_sel;
    logic signed [poi_pkg::POS_W:0]     acc_sum;
    logic signed [poi_pkg::POS_W-1:0]   acc_next;
    logic                               pose_valid_next;

    assign cw           = PROGRAM[pc_reg];
    assign sample_stall = !cw.accept;
    assign sample_fire  = sample_valid && cw.accept;
    assign out_busy     = pose_valid_reg && pose_stall;
    assign emit_fire    = cw.emit && !out_busy;
    assign pose_valid   = pose_valid_reg;
    assign pose         = pose_reg;

    always_comb
    begin
        case (cw.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_NO_REQ:   cond_hit = !sample_fire;
            COND_UNPRIMED: cond_hit = !primed_reg;
            COND_OUT_BUSY: cond_hit = out_busy;
            default:       cond_hit = 1'b0;
        endcase
    end

    assign trig = rom_neg_reg ? -$signed({1'b0, rom_data_reg}) : $signed({1'b0, rom_data_reg});

    always_comb
    begin
        case (cw.a_sel)
            A_SPEED: mul_a = {{17{v_reg[15]}}, v_reg};
            A_RATE:  mul_a = {{17{w_reg[15]}}, w_reg};
            A_PROD:  mul_a = mul_reg[32:0];
            A_PATH:  mul_a = path_reg;
            default: mul_a = path_reg;
        endcase
        case (cw.b_sel)
            B_DT:    mul_b = {9'b0, dt_reg};
            B_TRIG:  mul_b = {{9{trig[15]}}, trig};
            B_YAW_K: mul_b = poi_pkg::YAW_K_Q16;
            default: mul_b = {9'b0, dt_reg};
        endcase
    end

    assign prod = mul_a * mul_b;

    assign angle    = cw.rom_cos ? head_reg + poi_pkg::QUARTER_TURN : head_reg;
    assign idx      = angle[29 -: AW];
    assign rom_addr = angle[30] ? QTAB_TOP - {1'b0, idx} : {1'b0, idx};

    // round half up; position accumulates with saturation, heading wraps
    assign pos_sh  = (mul_reg + 58'sd16384) >>> 15;
    assign head_sh = (mul_reg + 58'sd32768) >>> 16;
    assign acc_sel = cw.ld_x ? x_reg : y_reg;
    assign acc_sum = {acc_sel[poi_pkg::POS_W-1], acc_sel} + pos_sh[poi_pkg::POS_W:0];

    always_comb
    begin
        if (acc_sum[poi_pkg::POS_W] != acc_sum[poi_pkg::POS_W-1])
        begin
            acc_next = acc_sum[poi_pkg::POS_W] ? poi_pkg::POS_MIN : poi_pkg::POS_MAX;
        end
        else
        begin
            acc_next = acc_sum[poi_pkg::POS_W-1:0];
        end
    end

    always_comb
    begin
        pose_valid_next = pose_valid_reg;
        if (emit_fire)
        begin
            pose_valid_next = 1'b1;
        end
        else if (pose_valid_reg && !pose_stall)
        begin
            pose_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= ST_IDLE;
            primed_reg     <= 1'b0;
            x_reg          <= '0;
            y_reg          <= '0;
            head_reg       <= '0;
            pose_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg         <= cond_hit ? cw.target : step_e'(pc_reg + 3'd1);
            pose_valid_reg <= pose_valid_next;
            if (cw.ld_x)
            begin
                x_reg <= acc_next;
            end
            if (cw.ld_y)
            begin
                y_reg <= acc_next;
            end
            if (cw.ld_head)
            begin
                head_reg <= head_reg + head_sh[poi_pkg::HEAD_W-1:0];
            end
            if (emit_fire)
            begin
                primed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg      <= prod;
        rom_data_reg <= SINE_ROM[rom_addr];
        rom_neg_reg  <= angle[31];
        if (cw.ld_path)
        begin
            path_reg <= mul_reg[32:0];
        end
        if (sample_fire)
        begin
            v_reg  <= sample.linear_speed;
            w_reg  <= sample.angular_rate;
            dt_reg <= sample.elapsed_ms;
        end
        if (emit_fire)
        begin
            pose_reg.pos_x      <= x_reg;
            pose_reg.pos_y      <= y_reg;
            pose_reg.yaw_angle  <= head_reg;
            pose_reg.integrated <= primed_reg;
        end
    end

endmodule

`default_nettype wire
